// File: hdl/kway_merge_min_heap_defines.svh
// Assertion macros for the k-way merge heap.
// No dependencies; included by modules that assert.
`ifndef KWAY_MERGE_MIN_HEAP_DEFINES_SVH
`define KWAY_MERGE_MIN_HEAP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define KMH_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define KMH_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: hdl/kmh_pkg.sv
// Shared types and constants for the k-way merge heap.
// No dependencies.
package kmh_pkg;
  localparam int MAX_ENTRIES = 1024;
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  typedef struct packed {
    logic [54:0] key;
    logic [47:0] prog;
  } entry_t;
endpackage

// File: hdl/kmh_store.sv
// Heap entry memory: one write port, one registered read port.
// Depends on kmh_pkg.
module kmh_store import kmh_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [MAX_ENTRIES];
  // Write and read the entry array.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/kway_merge_min_heap.sv
// K-way merge min-heap: top level with sequencer and shared compare.
// Depends on kmh_pkg, kmh_store and the defines header.
//
// One command at a time; busy is high while it runs, and the result
// strobes for one cycle at its end, in the first cycle that busy is low
// again. A load writes the new entry, then reads the top; a clear, or a
// command that changes nothing, only reads the top. A sift level that
// swaps uses the entry memory's read and write ports (read node, read
// left, read right, compare, two swap writes); one that stops ends at the
// compare. An advance bumps the top's position or replaces it with the
// last entry, then sifts from the root; a build sifts each parent node,
// last to first. The result cannot be held off by the receiver.
`include "kway_merge_min_heap_defines.svh"
module kway_merge_min_heap import kmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [23:0] word_index,
  input  logic [30:0] doc_index,
  input  logic [23:0] list_length,
  output logic        done,
  output logic        top_valid,
  output logic [23:0] top_word,
  output logic [30:0] top_doc,
  output logic [23:0] top_position,
  output logic [10:0] entry_count,
  output logic [1:0]  status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_ADV0 = 4'd1, S_ADV1 = 4'd2,
    S_ADV2 = 4'd3, S_RDN = 4'd4, S_RDL = 4'd5, S_RDR = 4'd6, S_CMP = 4'd7,
    S_SW = 4'd8, S_NXT = 4'd9, S_TOP0 = 4'd10, S_TOP1 = 4'd11,
    S_TOP2 = 4'd12, S_WLD = 4'd13;

  logic [3:0]    state;
  logic [CW-1:0] size;
  logic [CW-1:0] bidx;
  logic [CW:0]   idx;
  logic [CW:0]   best;
  entry_t        ent_n, ent_l, ent_r, ent_top;
  logic [30:0]   doc_hold;
  logic [1:0]    stat;
  logic          build;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic [CW:0]   lch, rch;
  logic          l_ok, r_ok;
  logic [23:0]   pos_inc;

  kmh_store u_store (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  assign busy = (state != S_IDLE);
  assign lch = {idx[CW-1:0], 1'b1};
  assign rch = lch + 1'b1;
  assign l_ok = lch < {1'b0, size};
  assign r_ok = rch < {1'b0, size};
  assign pos_inc = ent_n.prog[47:24] + 24'd1;

  // Drive memory ports from the sequencer.
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = ent_n;
    raddr = idx[AW-1:0];
    case (state)
      S_IDLE: raddr = '0;
      S_ADV0: raddr = AW'(size - 1'b1);
      S_RDN: raddr = idx[AW-1:0];
      S_RDL: raddr = lch[AW-1:0];
      S_RDR: raddr = rch[AW-1:0];
      S_TOP0: raddr = '0;
      S_WLD: begin
        we = 1'b1;
        waddr = size[AW-1:0];
        wdata.key = {doc_hold, ent_l.key[23:0]};
        wdata.prog = {24'd0, ent_l.prog[23:0]};
      end
      S_ADV2: begin
        we = 1'b1;
        waddr = '0;
        wdata = ent_n;
      end
      S_SW: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = (best == lch) ? ent_l : ent_r;
      end
      S_NXT: begin
        // Write the sinking entry only after a swap.
        we = (best != idx);
        waddr = best[AW-1:0];
        wdata = ent_n;
      end
      default: ;
    endcase
  end

  // Sequence commands.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          stat <= ST_OK;
          build <= 1'b0;
          doc_hold <= doc_index;
          ent_l.key <= {31'd0, word_index};
          ent_l.prog <= {24'd0, list_length};
          case (operation)
            OP_LOAD: begin
              if (list_length == 24'd0) state <= S_TOP0;
              else if (size >= CW'(MAX_ENTRIES)) begin
                stat <= ST_FULL;
                state <= S_TOP0;
              end else state <= S_WLD;
            end
            OP_BUILD: begin
              bidx <= size >> 1;
              build <= 1'b1;
              idx <= '0;
              best <= '0;
              state <= S_NXT;
            end
            OP_ADVANCE: begin
              if (size == '0) begin
                stat <= ST_EMPTY;
                state <= S_TOP0;
              end else state <= S_ADV0;
            end
            default: begin
              size <= '0;
              state <= S_TOP0;
            end
          endcase
        end
        S_WLD: begin
          size <= size + 1'b1;
          state <= S_TOP0;
        end
        S_ADV0: begin
          ent_n <= rdata;
          state <= S_ADV1;
        end
        S_ADV1: begin
          if (pos_inc < ent_n.prog[23:0]) begin
            ent_n.key <= {doc_hold, ent_n.key[23:0]};
            ent_n.prog <= {pos_inc, ent_n.prog[23:0]};
          end else begin
            ent_n <= rdata;
            size <= size - 1'b1;
          end
          state <= S_ADV2;
        end
        S_ADV2: begin
          idx <= '0;
          state <= S_RDN;
        end
        S_RDN: state <= S_RDL;
        S_RDL: begin
          ent_n <= rdata;
          state <= S_RDR;
        end
        S_RDR: begin
          ent_l <= rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          // Pick the smallest of node and its children.
          if (r_ok && rdata.key < ent_n.key && !(l_ok && ent_l.key <= rdata.key)) begin
            best <= rch;
            ent_r <= rdata;
            state <= S_SW;
          end else if (l_ok && ent_l.key < ent_n.key) begin
            best <= lch;
            state <= S_SW;
          end else begin
            state <= build ? S_NXT : S_TOP0;
            best <= idx;
          end
        end
        S_SW: begin
          state <= S_NXT;
        end
        S_NXT: begin
          // Continue the sift from the swapped child, or pick next build node.
          if (best != idx) begin
            idx <= best;
            state <= S_RDN;
          end else if (build && bidx != '0) begin
            bidx <= bidx - 1'b1;
            idx <= {1'b0, bidx - 1'b1};
            best <= {1'b0, bidx - 1'b1};
            state <= S_RDN;
          end else state <= S_TOP0;
        end
        S_TOP0: state <= S_TOP1;
        S_TOP1: begin
          ent_top <= rdata;
          state <= S_TOP2;
        end
        S_TOP2: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Present the result beat.
  always_comb begin
    top_valid = (size != '0);
    top_word = top_valid ? ent_top.key[23:0] : 24'd0;
    top_doc = top_valid ? ent_top.key[54:24] : 31'd0;
    top_position = top_valid ? ent_top.prog[47:24] : 24'd0;
    entry_count = 11'(size);
    status = stat;
  end

  `KMH_ASSERT_IMP(a_size_max, clk, rst, 1'b1, size <= CW'(MAX_ENTRIES))
  `KMH_ASSERT_IMP(a_done_busy, clk, rst, done, !busy)
  `KMH_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule
